// ----- hw/rtl/vole_cpu_step_assert.svh -----
// Assertion macros for the vole CPU step block.
// Pulled in by the top level with `include; needs no other file.
`ifndef VOLE_CPU_STEP_ASSERT_SVH
`define VOLE_CPU_STEP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VOLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/vole_pkg.sv -----
// Shared types and constants for the vole CPU step block.
// No dependencies; used by vole_alu and vole_cpu_step.
package vole_pkg;

  localparam int unsigned MEM_DEPTH = 256;
  localparam int unsigned MEM_AW    = 8;
  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_AW    = 4;

  localparam logic [3:0] OP_LOAD_MEM = 4'h1;
  localparam logic [3:0] OP_LOAD_IMM = 4'h2;
  localparam logic [3:0] OP_STORE    = 4'h3;
  localparam logic [3:0] OP_MOVE     = 4'h4;
  localparam logic [3:0] OP_ADD      = 4'h5;
  localparam logic [3:0] OP_OR       = 4'h7;
  localparam logic [3:0] OP_AND      = 4'h8;
  localparam logic [3:0] OP_XOR      = 4'h9;
  localparam logic [3:0] OP_ROT      = 4'hA;
  localparam logic [3:0] OP_BR_EQ    = 4'hB;
  localparam logic [3:0] OP_HALT     = 4'hC;
  localparam logic [3:0] OP_BR_GT    = 4'hD;

  // request kinds on in_func
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_EXEC  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic [7:0] res;
    logic       eq;
    logic       gt;
  } alu_out_t;

  function automatic logic [7:0] rot_right8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] dbl;
    begin
      dbl = {v, v} >> n;
      return dbl[7:0];
    end
  endfunction

endpackage

// ----- hw/rtl/vole_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module vole_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/vole_alu.sv -----
// Shared 8-bit ALU: add, logic ops, rotate, compare against R0.
// Depends on vole_pkg.
module vole_alu (
  input  logic [3:0]          op,
  input  logic [7:0]          a,
  input  logic [7:0]          b,
  input  logic [2:0]          cnt,
  output vole_pkg::alu_out_t  q
);

  always_comb begin
    q.eq = (a == b);
    q.gt = (a > b);
    unique case (op)
      vole_pkg::OP_ADD: q.res = a + b;
      vole_pkg::OP_OR:  q.res = a | b;
      vole_pkg::OP_AND: q.res = a & b;
      vole_pkg::OP_XOR: q.res = a ^ b;
      vole_pkg::OP_ROT: q.res = vole_pkg::rot_right8(a, cnt);
      default:          q.res = a;  // move passes the source through
    endcase
  end

endmodule

// ----- hw/rtl/vole_cpu_step.sv -----
// Top level of the vole CPU step block: sequencer, register file, memory.
// Depends on vole_pkg, vole_ram, vole_alu and vole_cpu_step_assert.svh.
//
// One request per start pulse (taken when busy is low); every request yields
// exactly one result, shown for a single cycle with out_valid high. There is
// no backpressure: the receiver must take the result in that cycle. Memory
// writes, unused func codes and execute requests while halted give their
// result on the next cycle and leave busy low; a memory read waits in
// RD_WAIT; an executed instruction makes two byte fetches and an operand
// access through the single memory port, then two register reads through
// the single register-file read port. Memory and registers read as zero
// until written; no clearing pass is needed after reset. cfg_ready is high
// only while no request is in flight and none is offered on start.
`include "vole_cpu_step_assert.svh"

module vole_cpu_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_mem_address,
  input  logic [7:0]  in_mem_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_start_address,
  output logic        out_valid,
  output logic [7:0]  out_pc_of_item,
  output logic [15:0] out_instr_word,
  output logic        out_stopped,
  output logic        out_fault,
  output logic        out_screen_valid,
  output logic [7:0]  out_screen_value,
  output logic [7:0]  out_read_data
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RD_WAIT  = 3'd1;
  localparam logic [2:0] ST_FETCH_HI = 3'd2;
  localparam logic [2:0] ST_FETCH_LO = 3'd3;
  localparam logic [2:0] ST_EXEC_A   = 3'd4;
  localparam logic [2:0] ST_EXEC_B   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [7:0]  pc_r, pc_nxt;
  logic        halted_r, halted_nxt;
  logic [15:0] ir_r, ir_nxt;
  logic [7:0]  opa_r, opa_nxt;
  logic [7:0]  regs_r [vole_pkg::REG_COUNT];
  logic [vole_pkg::MEM_DEPTH-1:0] mem_valid_r;
  logic        rvalid_r;

  logic        ov_r, ov_nxt;
  logic [7:0]  o_pc_r, o_pc_nxt;
  logic [15:0] o_word_r, o_word_nxt;
  logic        o_fault_r, o_fault_nxt;
  logic        o_scr_v_r, o_scr_v_nxt;
  logic [7:0]  o_scr_d_r, o_scr_d_nxt;
  logic [7:0]  o_rd_r, o_rd_nxt;

  logic                       ram_we;
  logic [vole_pkg::MEM_AW-1:0] ram_addr;
  logic [7:0]                 ram_wdata, ram_rdata, mem_byte;

  logic [vole_pkg::REG_AW-1:0] rf_rd_idx, rf_wr_idx;
  logic [7:0]  rf_rd, rf_wdata;
  logic        rf_we;

  logic [3:0]  op;
  logic [7:0]  xy;
  logic [8:0]  next_pc;
  logic        accept, jump;
  vole_pkg::alu_out_t alu_q;

  assign accept   = start && (state_r == ST_IDLE);
  assign op       = ir_r[15:12];
  assign xy       = ir_r[7:0];
  assign next_pc  = {1'b0, pc_r} + 9'd2;
  assign mem_byte = rvalid_r ? ram_rdata : 8'd0;
  assign rf_rd    = regs_r[rf_rd_idx];

  vole_ram #(.WIDTH(8), .DEPTH(vole_pkg::MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  vole_alu u_alu (
    .op  (op),
    .a   (opa_r),
    .b   (rf_rd),
    .cnt (ir_r[2:0]),
    .q   (alu_q)
  );

  // register-file read index: first operand in EXEC_A, second in EXEC_B
  always_comb begin
    rf_rd_idx = ir_r[11:8];
    if (state_r == ST_EXEC_A) begin
      unique case (op)
        vole_pkg::OP_MOVE, vole_pkg::OP_ADD, vole_pkg::OP_OR,
        vole_pkg::OP_AND, vole_pkg::OP_XOR: rf_rd_idx = ir_r[7:4];
        default:                            rf_rd_idx = ir_r[11:8];
      endcase
    end else begin
      unique case (op)
        vole_pkg::OP_ADD, vole_pkg::OP_OR,
        vole_pkg::OP_AND, vole_pkg::OP_XOR: rf_rd_idx = ir_r[3:0];
        default:                            rf_rd_idx = '0;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    halted_nxt  = halted_r;
    ir_nxt      = ir_r;
    opa_nxt     = opa_r;
    ov_nxt      = 1'b0;
    o_pc_nxt    = 8'd0;
    o_word_nxt  = 16'd0;
    o_fault_nxt = 1'b0;
    o_scr_v_nxt = 1'b0;
    o_scr_d_nxt = 8'd0;
    o_rd_nxt    = 8'd0;
    ram_we      = 1'b0;
    ram_addr    = in_mem_address;
    ram_wdata   = opa_r;
    rf_we       = 1'b0;
    rf_wr_idx   = ir_r[11:8];
    rf_wdata    = alu_q.res;
    jump        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          // restart: pc from the new start address, halt cleared
          pc_nxt     = cfg_start_address;
          halted_nxt = 1'b0;
        end
        if (accept) begin
          if (in_func == vole_pkg::FUNC_READ) begin
            state_nxt = ST_RD_WAIT;
          end else if (in_func == vole_pkg::FUNC_EXEC && !halted_r) begin
            ram_addr  = pc_r;
            state_nxt = ST_FETCH_HI;
          end else begin
            ov_nxt = 1'b1;
            if (in_func == vole_pkg::FUNC_WRITE) begin
              ram_we    = 1'b1;
              ram_wdata = in_mem_data;
            end
          end
        end
      end
      ST_RD_WAIT: begin
        ov_nxt    = 1'b1;
        o_rd_nxt  = mem_byte;
        state_nxt = ST_IDLE;
      end
      ST_FETCH_HI: begin
        ir_nxt[15:8] = mem_byte;
        ram_addr     = pc_r + 8'd1;  // wraps at the top of memory
        state_nxt    = ST_FETCH_LO;
      end
      ST_FETCH_LO: begin
        ir_nxt[7:0] = mem_byte;
        state_nxt   = ST_EXEC_A;
      end
      ST_EXEC_A: begin
        opa_nxt   = rf_rd;
        ram_addr  = xy;  // operand read for load-from-memory
        state_nxt = ST_EXEC_B;
      end
      ST_EXEC_B: begin
        ram_addr   = xy;
        ov_nxt     = 1'b1;
        o_pc_nxt   = pc_r;
        o_word_nxt = ir_r;
        unique case (op)
          vole_pkg::OP_LOAD_MEM: begin
            rf_we    = 1'b1;
            rf_wdata = mem_byte;
          end
          vole_pkg::OP_LOAD_IMM: begin
            rf_we    = 1'b1;
            rf_wdata = xy;
          end
          vole_pkg::OP_STORE: begin
            ram_we      = 1'b1;
            o_scr_v_nxt = (xy == 8'd0);
            o_scr_d_nxt = (xy == 8'd0) ? opa_r : 8'd0;
          end
          vole_pkg::OP_MOVE: begin
            rf_we     = 1'b1;
            rf_wr_idx = ir_r[3:0];
          end
          vole_pkg::OP_ADD, vole_pkg::OP_OR, vole_pkg::OP_AND,
          vole_pkg::OP_XOR, vole_pkg::OP_ROT: begin
            rf_we = 1'b1;
          end
          vole_pkg::OP_BR_EQ: jump = alu_q.eq;
          vole_pkg::OP_BR_GT: jump = alu_q.gt;
          vole_pkg::OP_HALT:  halted_nxt = 1'b1;
          default: begin
            o_fault_nxt = 1'b1;
            halted_nxt  = 1'b1;
          end
        endcase
        if (jump) begin
          pc_nxt = xy;
        end else begin
          pc_nxt = next_pc[7:0];
          if (next_pc[8]) begin
            halted_nxt = 1'b1;
          end
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= 8'd0;
      halted_r    <= 1'b0;
      ov_r        <= 1'b0;
      mem_valid_r <= '0;
      for (int i = 0; i < vole_pkg::REG_COUNT; i++) begin
        regs_r[i] <= 8'd0;
      end
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      halted_r <= halted_nxt;
      ov_r     <= ov_nxt;
      if (ram_we) begin
        mem_valid_r[ram_addr] <= 1'b1;
      end
      if (rf_we) begin
        regs_r[rf_wr_idx] <= rf_wdata;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    ir_r      <= ir_nxt;
    opa_r     <= opa_nxt;
    rvalid_r  <= mem_valid_r[ram_addr];
    o_pc_r    <= o_pc_nxt;
    o_word_r  <= o_word_nxt;
    o_fault_r <= o_fault_nxt;
    o_scr_v_r <= o_scr_v_nxt;
    o_scr_d_r <= o_scr_d_nxt;
    o_rd_r    <= o_rd_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  // a restart never shares an edge with an accepted request
  assign cfg_ready        = (state_r == ST_IDLE) && !start;
  assign out_valid        = ov_r;
  assign out_pc_of_item   = o_pc_r;
  assign out_instr_word   = o_word_r;
  assign out_stopped      = halted_r;
  assign out_fault        = o_fault_r;
  assign out_screen_valid = o_scr_v_r;
  assign out_screen_value = o_scr_d_r;
  assign out_read_data    = o_rd_r;

  `VOLE_ASSERT_NOW(a_fault_stops, out_valid && out_fault, out_stopped, "fault without halt")
  `VOLE_ASSERT_NOW(a_screen_store, out_valid && out_screen_valid,
    (out_instr_word[15:12] == vole_pkg::OP_STORE) && (out_instr_word[7:0] == 8'd0),
    "screen output without store to zero")
  `VOLE_ASSERT_NEXT(a_restart, cfg_valid && cfg_ready,
    !halted_r && (pc_r == $past(cfg_start_address)), "restart did not load pc")
  `VOLE_ASSERT_NEXT(a_fetch_seq, state_r == ST_FETCH_HI, state_r == ST_FETCH_LO,
    "fetch sequence broken")

endmodule
